@@ rtl/core/spb_pkg.sv @@
// Shared constants and controller/datapath interface types for the palindrome builder.
package spb_pkg;

    // Default string capacity in bytes
    localparam int MAX_LEN_DEF = 32;
    // Width of one character
    localparam int CHAR_W = 8;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic load;        // store the accepted input byte
        logic start;       // the accepted byte ends the string: latch length, clear search
        logic next_k;      // compare matched: step the inner index
        logic next_shift;  // compare failed: try the next shorter prefix
        logic rd_emit;     // read port A addresses the emission sequence
        logic emit_start;  // set up emission of the tail then the body
        logic emit_ld;     // load the output register and step the emission index
        logic finish;      // string done: clear count and overflow flag
    } spb_cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic shift_end;   // only a one-byte prefix is left
        logic pal_done;    // every pair of the current prefix matched
        logic match;       // the two read bytes are equal
        logic emit_end;    // the current emission word is the final one
        logic out_free;    // output register can take a word this cycle
    } spb_stat_t;

endpackage

@@ rtl/core/spb_ctrl.sv @@
// Controller state machine: load, prefix search and emission sequencing.
module spb_ctrl
    import spb_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    input  logic      in_last,
    output logic      in_ready,
    input  spb_stat_t stat,
    output spb_cmd_t  cmd
);

    typedef enum logic [2:0] {
        S_LOAD,
        S_SRCH_RD,
        S_SRCH_CMP,
        S_EMIT_RD,
        S_EMIT_LD
    } state_t;

    state_t state_reg;
    state_t state_next;

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            S_LOAD:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load = 1'b1;
                    if (in_last)
                    begin
                        cmd.start  = 1'b1;
                        state_next = S_SRCH_RD;
                    end
                end
            end
            S_SRCH_RD:
            begin
                // Reads for the current pair are issued here
                if (stat.shift_end || stat.pal_done)
                begin
                    cmd.emit_start = 1'b1;
                    state_next     = S_EMIT_RD;
                end
                else
                begin
                    state_next = S_SRCH_CMP;
                end
            end
            S_SRCH_CMP:
            begin
                if (stat.match)
                begin
                    cmd.next_k = 1'b1;
                end
                else
                begin
                    cmd.next_shift = 1'b1;
                end
                state_next = S_SRCH_RD;
            end
            S_EMIT_RD:
            begin
                cmd.rd_emit = 1'b1;
                state_next  = S_EMIT_LD;
            end
            S_EMIT_LD:
            begin
                cmd.rd_emit = 1'b1;
                if (stat.out_free)
                begin
                    cmd.emit_ld = 1'b1;
                    if (stat.emit_end)
                    begin
                        cmd.finish = 1'b1;
                        state_next = S_LOAD;
                    end
                    else
                    begin
                        state_next = S_EMIT_RD;
                    end
                end
            end
            default:
            begin
                state_next = S_LOAD;
            end
        endcase
    end

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_LOAD;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

@@ rtl/core/spb_dp.sv @@
// Datapath: string memory, counters, pair comparator and output register.
module spb_dp
    import spb_pkg::*;
#(
    parameter int MAX_LEN = MAX_LEN_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic [CHAR_W-1:0] in_char,
    input  spb_cmd_t          cmd,
    output spb_stat_t         stat,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [CHAR_W-1:0] out_char,
    output logic              out_last,
    output logic              out_trunc
);

    localparam int CNT_W  = $clog2(MAX_LEN + 1);
    localparam int ADDR_W = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(MAX_LEN);
    localparam logic [CNT_W-1:0] ONE      = CNT_W'(1);

    logic [CHAR_W-1:0] store_mem [MAX_LEN];

    logic [CNT_W-1:0]  count_reg, count_next;
    logic              ovf_reg, ovf_next;
    logic [CNT_W-1:0]  n_reg, n_next;
    logic [CNT_W-1:0]  shift_reg, shift_next;
    logic [CNT_W-1:0]  k_reg, k_next;
    logic              phase_reg, phase_next;   // 0: reversed tail, 1: body
    logic [CHAR_W-1:0] rd_a_reg, rd_b_reg;
    logic              out_valid_reg, out_valid_next;
    logic [CHAR_W-1:0] out_char_reg;
    logic              out_last_reg;
    logic              out_trunc_reg;

    logic              full;
    logic [CNT_W-1:0]  len;
    logic [CNT_W-1:0]  addr_a, addr_b;
    logic [CNT_W-1:0]  n_m1;

    assign full = (count_reg == FULL_CNT);
    assign len  = n_reg - shift_reg;
    assign n_m1 = n_reg - ONE;

    // Read addresses: search pairs, or emission sequence on port A
    always_comb
    begin
        if (cmd.rd_emit)
        begin
            addr_a = phase_reg ? k_reg : (n_m1 - k_reg);
        end
        else
        begin
            addr_a = k_reg;
        end
        addr_b = len - ONE - k_reg;
    end

    // Status
    always_comb
    begin
        stat.shift_end = ((shift_reg + ONE) >= n_reg);
        stat.pal_done  = (k_reg >= (len >> 1));
        stat.match     = (rd_a_reg == rd_b_reg);
        stat.emit_end  = phase_reg && (k_reg == n_m1);
        stat.out_free  = !out_valid_reg || out_ready;
    end

    // String memory with registered reads
    always_ff @(posedge clk)
    begin
        if (cmd.load && !full)
        begin
            store_mem[count_reg[ADDR_W-1:0]] <= in_char;
        end
        rd_a_reg <= store_mem[addr_a[ADDR_W-1:0]];
        rd_b_reg <= store_mem[addr_b[ADDR_W-1:0]];
    end

    // Counter and index updates
    always_comb
    begin
        count_next     = count_reg;
        ovf_next       = ovf_reg;
        n_next         = n_reg;
        shift_next     = shift_reg;
        k_next         = k_reg;
        phase_next     = phase_reg;
        out_valid_next = out_valid_reg && !out_ready;
        if (cmd.load)
        begin
            if (full)
            begin
                ovf_next = 1'b1;
            end
            else
            begin
                count_next = count_reg + ONE;
            end
        end
        if (cmd.start)
        begin
            n_next     = full ? count_reg : (count_reg + ONE);
            shift_next = '0;
            k_next     = '0;
        end
        if (cmd.next_k)
        begin
            k_next = k_reg + ONE;
        end
        if (cmd.next_shift)
        begin
            shift_next = shift_reg + ONE;
            k_next     = '0;
        end
        if (cmd.emit_start)
        begin
            phase_next = (shift_reg == '0);
            k_next     = '0;
        end
        if (cmd.emit_ld)
        begin
            out_valid_next = 1'b1;
            if (!phase_reg && (k_reg == (shift_reg - ONE)))
            begin
                phase_next = 1'b1;
                k_next     = '0;
            end
            else
            begin
                k_next = k_reg + ONE;
            end
        end
        if (cmd.finish)
        begin
            count_next = '0;
            ovf_next   = 1'b0;
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            ovf_reg       <= 1'b0;
            n_reg         <= '0;
            shift_reg     <= '0;
            k_reg         <= '0;
            phase_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            ovf_reg       <= ovf_next;
            n_reg         <= n_next;
            shift_reg     <= shift_next;
            k_reg         <= k_next;
            phase_reg     <= phase_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Output word register
    always_ff @(posedge clk)
    begin
        if (cmd.emit_ld)
        begin
            out_char_reg  <= rd_a_reg;
            out_last_reg  <= stat.emit_end;
            out_trunc_reg <= ovf_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_char  = out_char_reg;
    assign out_last  = out_last_reg;
    assign out_trunc = out_trunc_reg;

endmodule

@@ rtl/core/shortest_palindrome_builder_unit.sv @@
// Search: bytes are stored as they are accepted, up to MAX_LEN; after the last byte, prefixes are tried
// from longest to shortest, with one memory compare per pair.
// Emission: each output word takes a memory read, then a load into the output register; output stalls hold it.
// Strings: one at a time; 2*n-1 output words at most.
// The input is accepted again once the final word is in the output register.
// Reset: asynchronous, active low; clears count, overflow flag and control state, not the memory.
module shortest_palindrome_builder_unit
    import spb_pkg::*;
#(
    parameter int MAX_LEN = MAX_LEN_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [CHAR_W-1:0] s_tdata,   // [7:0] char_in
    input  logic              s_tlast,   // last_in
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [CHAR_W-1:0] m_tdata,   // [7:0] char_out
    output logic              m_tlast,   // last_out
    output logic              m_tuser    // [0] truncated
);

    spb_cmd_t  cmd;
    spb_stat_t stat;

    spb_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_last  (s_tlast),
        .in_ready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    spb_dp #(
        .MAX_LEN (MAX_LEN)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_char   (s_tdata),
        .cmd       (cmd),
        .stat      (stat),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_char  (m_tdata),
        .out_last  (m_tlast),
        .out_trunc (m_tuser)
    );

endmodule

@@ rtl/core/spb_checker.sv @@
// Port-level checker for the palindrome builder, bound to the top level.
module spb_checker
    import spb_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              s_tvalid,
    input logic              s_tready,
    input logic              s_tlast,
    input logic              m_tvalid,
    input logic              m_tready,
    input logic [CHAR_W-1:0] m_tdata,
    input logic              m_tlast,
    input logic              m_tuser
);

    // A stalled output word holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)
            && $stable(m_tlast) && $stable(m_tuser)))
        else $error("output word changed while stalled");

    // End of string starts the search: input is closed next cycle
    a_last_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready && s_tlast) |=> !s_tready)
        else $error("input still open after last byte");

    // A byte within a string keeps the input open
    a_mid_open: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready && !s_tlast) |=> s_tready)
        else $error("input closed in the middle of a string");

    // While a result is still being emitted, no new byte is taken
    a_emit_closed: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tready && !m_tlast) |-> !s_tready)
        else $error("input open during emission");

endmodule

bind shortest_palindrome_builder_unit spb_checker u_spb_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
);
